@@ hw/rtl/ps2_set1_scancode_decoder_defines.svh @@
// Assertion macros shared by the decoder's modules.
`ifndef PS2_SET1_SCANCODE_DECODER_DEFINES_SVH
`define PS2_SET1_SCANCODE_DECODER_DEFINES_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ hw/rtl/ps2s1_pkg.sv @@
package ps2s1_pkg;

  localparam int KEY_CODES = 128;
  localparam int KEY_IDX_W = $clog2(KEY_CODES);

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] PREFIX_BYTE    = 8'hE0;
  localparam logic [7:0] LSHIFT_MAKE    = 8'h2A;
  localparam logic [7:0] RSHIFT_MAKE    = 8'h36;
  localparam logic [7:0] LSHIFT_BREAK   = 8'hAA;
  localparam logic [7:0] RSHIFT_BREAK   = 8'hB6;
  localparam logic [7:0] CTRL_MAKE      = 8'h1D;
  localparam logic [7:0] CTRL_BREAK     = 8'h9D;
  localparam logic [7:0] ALT_MAKE       = 8'h38;
  localparam logic [7:0] ALT_BREAK      = 8'hB8;
  localparam logic [7:0] LLOGO_MAKE     = 8'h5B;
  localparam logic [7:0] RLOGO_MAKE     = 8'h5C;
  localparam logic [7:0] LLOGO_BREAK    = 8'hDB;
  localparam logic [7:0] RLOGO_BREAK    = 8'hDC;

  typedef struct packed {
    logic       extended;
    logic [7:0] key_code;
    logic       is_release;
    logic       shift_down;
    logic       ctrl_down;
    logic       alt_down;
    logic       altgr_down;
    logic       logo_down;
  } key_evt_t;

  typedef struct packed {
    logic     valid;
    key_evt_t evt;
  } evt_push_t;

endpackage

@@ hw/rtl/ps2_set1_scancode_decoder.sv @@
// An accepted byte that yields an event is registered into the decode stage, where its
// down bit arrives from the key map, and is then written into the event queue behind out_valid.
// Throughput: one byte per cycle; the input stalls while the key map is cleared after reset
// and once the decode stage and the four-entry event queue together hold four entries.
// Reset (rst_n low, synchronous) clears the prefix and modifier flags and the queue, then
// a pass over all 128 key codes clears the key-down map while in_ready is held low.
module ps2_set1_scancode_decoder import ps2s1_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_scan_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_extended,
  output logic [7:0] out_key_code,
  output logic       out_is_release,
  output logic       out_shift_down,
  output logic       out_ctrl_down,
  output logic       out_alt_down,
  output logic       out_altgr_down,
  output logic       out_logo_down
);

  evt_push_t             push;
  logic [FIFO_CNT_W-1:0] q_level;
  key_evt_t              evt;

  ps2s1_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_scan_byte (in_scan_byte),
    .q_level      (q_level),
    .push         (push)
  );

  ps2s1_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .level     (q_level),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_evt   (evt)
  );

  assign out_extended   = evt.extended;
  assign out_key_code   = evt.key_code;
  assign out_is_release = evt.is_release;
  assign out_shift_down = evt.shift_down;
  assign out_ctrl_down  = evt.ctrl_down;
  assign out_alt_down   = evt.alt_down;
  assign out_altgr_down = evt.altgr_down;
  assign out_logo_down  = evt.logo_down;

endmodule

@@ hw/rtl/ps2s1_front.sv @@
`include "ps2_set1_scancode_decoder_defines.svh"

module ps2s1_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  assign rdata = rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

endmodule

module ps2s1_front import ps2s1_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_scan_byte,
  input  logic [FIFO_CNT_W-1:0] q_level,
  output evt_push_t             push
);

  logic                 prefix_r, prefix_nxt;
  logic                 shift_r, shift_nxt;
  logic                 ctrl_r, ctrl_nxt;
  logic                 alt_r, alt_nxt;
  logic                 altgr_r, altgr_nxt;
  logic                 logo_r, logo_nxt;
  logic                 clr_active_r;
  logic [KEY_IDX_W-1:0] clr_addr_r;
  logic                 s2_valid_r;
  key_evt_t             s2_evt_r;
  logic                 s2_fwd_r;
  logic                 s2_fwd_val_r;

  logic                 accept;
  logic                 is_prefix;
  logic                 is_mod;
  logic                 is_key;
  logic                 rel;
  logic [KEY_IDX_W-1:0] idx;
  logic [KEY_IDX_W-1:0] s2_idx;
  logic                 s2_down;
  logic                 s2_emit;
  logic                 map_we;
  logic [KEY_IDX_W-1:0] map_waddr;
  logic                 map_wdata;
  logic                 map_rdata;

  // Room is kept for the event in the decode stage as well as for the new request,
  // so the decode stage never has to wait on the queue.
  assign in_ready  = !clr_active_r &&
                     ((q_level + FIFO_CNT_W'(s2_valid_r)) < FIFO_CNT_W'(FIFO_DEPTH));
  assign accept    = in_valid && in_ready;
  assign is_prefix = (in_scan_byte == PREFIX_BYTE);
  assign idx       = in_scan_byte[KEY_IDX_W-1:0];
  assign rel       = in_scan_byte[7];
  assign is_key    = !is_prefix && !is_mod;
  assign prefix_nxt = is_prefix;

  // Modifier bytes are absorbed; which set applies depends on the prefix.
  always_comb begin
    is_mod    = 1'b0;
    shift_nxt = shift_r;
    ctrl_nxt  = ctrl_r;
    alt_nxt   = alt_r;
    altgr_nxt = altgr_r;
    logo_nxt  = logo_r;
    if (!prefix_r) begin
      case (in_scan_byte)
        LSHIFT_MAKE, RSHIFT_MAKE: begin
          is_mod = 1'b1; shift_nxt = 1'b1;
        end
        LSHIFT_BREAK, RSHIFT_BREAK: begin
          is_mod = 1'b1; shift_nxt = 1'b0;
        end
        CTRL_MAKE: begin
          is_mod = 1'b1; ctrl_nxt = 1'b1;
        end
        CTRL_BREAK: begin
          is_mod = 1'b1; ctrl_nxt = 1'b0;
        end
        ALT_MAKE: begin
          is_mod = 1'b1; alt_nxt = 1'b1;
        end
        ALT_BREAK: begin
          is_mod = 1'b1; alt_nxt = 1'b0;
        end
        default: begin
          is_mod = 1'b0;
        end
      endcase
    end else begin
      case (in_scan_byte)
        ALT_MAKE: begin
          is_mod = 1'b1; altgr_nxt = 1'b1;
        end
        ALT_BREAK: begin
          is_mod = 1'b1; altgr_nxt = 1'b0;
        end
        LLOGO_MAKE, RLOGO_MAKE: begin
          is_mod = 1'b1; logo_nxt = 1'b1;
        end
        LLOGO_BREAK, RLOGO_BREAK: begin
          is_mod = 1'b1; logo_nxt = 1'b0;
        end
        default: begin
          is_mod = 1'b0;
        end
      endcase
    end
  end

  // The down bit is read from the key map at the edge that accepts the request and arrives in
  // the cycle after. When the request just before wrote the same bit at that edge, its value is used instead.
  assign s2_idx  = s2_evt_r.key_code[KEY_IDX_W-1:0];
  assign s2_down = s2_fwd_r ? s2_fwd_val_r : map_rdata;
  // A make of a key already down is a typematic repeat and is dropped.
  assign s2_emit = s2_evt_r.is_release || !s2_down;

  always_comb begin
    if (clr_active_r) begin
      map_we    = 1'b1;
      map_waddr = clr_addr_r;
      map_wdata = 1'b0;
    end else begin
      map_we    = s2_valid_r;
      map_waddr = s2_idx;
      map_wdata = !s2_evt_r.is_release;
    end
  end

  ps2s1_ram #(
    .WIDTH (1),
    .DEPTH (KEY_CODES)
  ) u_key_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .re    (accept),
    .raddr (idx),
    .rdata (map_rdata)
  );

  always_comb begin
    push.valid = s2_valid_r && s2_emit;
    push.evt   = s2_evt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_r     <= 1'b0;
      shift_r      <= 1'b0;
      ctrl_r       <= 1'b0;
      alt_r        <= 1'b0;
      altgr_r      <= 1'b0;
      logo_r       <= 1'b0;
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
      s2_valid_r   <= 1'b0;
      s2_evt_r     <= '0;
      s2_fwd_r     <= 1'b0;
      s2_fwd_val_r <= 1'b0;
    end else begin
      if (clr_active_r) begin
        clr_addr_r <= clr_addr_r + KEY_IDX_W'(1);
        if (clr_addr_r == KEY_IDX_W'(KEY_CODES - 1)) begin
          clr_active_r <= 1'b0;
        end
      end
      s2_valid_r <= accept && is_key;
      if (accept) begin
        prefix_r   <= prefix_nxt;
        shift_r    <= is_prefix ? shift_r : shift_nxt;
        ctrl_r     <= is_prefix ? ctrl_r : ctrl_nxt;
        alt_r      <= is_prefix ? alt_r : alt_nxt;
        altgr_r    <= is_prefix ? altgr_r : altgr_nxt;
        logo_r     <= is_prefix ? logo_r : logo_nxt;
        s2_evt_r.extended   <= prefix_r;
        s2_evt_r.key_code   <= in_scan_byte;
        s2_evt_r.is_release <= rel;
        s2_evt_r.shift_down <= shift_r;
        s2_evt_r.ctrl_down  <= ctrl_r;
        s2_evt_r.alt_down   <= alt_r;
        s2_evt_r.altgr_down <= altgr_r;
        s2_evt_r.logo_down  <= logo_r;
        s2_fwd_r     <= s2_valid_r && (s2_idx == idx);
        s2_fwd_val_r <= !s2_evt_r.is_release;
      end
    end
  end

  `ASSERT_NEXT(a_prefix_sets, clk, rst_n, accept && is_prefix, prefix_r)
  `ASSERT_IMPLY(a_no_accept_clearing, clk, rst_n, clr_active_r, !in_ready)
  `ASSERT_NEXT(a_key_staged, clk, rst_n, accept && is_key, s2_valid_r)
  `ASSERT_IMPLY(a_push_from_stage, clk, rst_n, push.valid, s2_valid_r)

endmodule

@@ hw/rtl/ps2s1_fifo.sv @@
`include "ps2_set1_scancode_decoder_defines.svh"

module ps2s1_fifo import ps2s1_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  evt_push_t             push,
  output logic [FIFO_CNT_W-1:0] level,
  output logic                  out_valid,
  input  logic                  out_ready,
  output key_evt_t              out_evt
);

  key_evt_t              mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CNT_W-1:0] count_r, count_nxt;
  logic                  room;
  logic                  do_push, do_pop;

  assign room      = (count_r != FIFO_CNT_W'(FIFO_DEPTH));
  assign level     = count_r;
  assign out_valid = (count_r != '0);
  assign out_evt   = mem_r[rd_ptr_r];
  assign do_push   = push.valid && room;
  assign do_pop    = out_valid && out_ready;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + FIFO_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_PTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.evt;
    end
  end

  `ASSERT_IMPLY(a_cnt_bound, clk, rst_n, 1'b1, count_r <= FIFO_CNT_W'(FIFO_DEPTH))
  `ASSERT_NEXT(a_cnt_grows, clk, rst_n, do_push && !do_pop, count_r == $past(count_r) + FIFO_CNT_W'(1))
  `ASSERT_IMPLY(a_no_push_full, clk, rst_n, push.valid, room)

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import ps2s1_pkg::*;

  typedef struct {
    logic [7:0] scan;
    bit         pinned;
    bit         emits;
    key_evt_t   evt;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_scan_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_extended;
  logic [7:0] out_key_code;
  logic       out_is_release;
  logic       out_shift_down;
  logic       out_ctrl_down;
  logic       out_alt_down;
  logic       out_altgr_down;
  logic       out_logo_down;

  // Predictor state, mirrors the decoder.
  logic prefix_seen = 1'b0;
  logic shift_on = 1'b0;
  logic ctrl_on = 1'b0;
  logic alt_on = 1'b0;
  logic altgr_on = 1'b0;
  logic logo_on = 1'b0;
  logic key_is_down [KEY_CODES];

  stim_row_t  offered_rows[$];
  key_evt_t   pending_events[$];
  logic [8:0] held_keys[$];
  logic [8:0] modifier_keys[14];

  bit idle_on = 1'b0;
  bit hold_long = 1'b0;
  int unsigned typed_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned events_checked = 0;
  int unsigned releases_seen = 0;
  int unsigned extended_seen = 0;
  int unsigned mismatch_count = 0;

  ps2_set1_scancode_decoder u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_scan_byte   (in_scan_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_extended   (out_extended),
    .out_key_code   (out_key_code),
    .out_is_release (out_is_release),
    .out_shift_down (out_shift_down),
    .out_ctrl_down  (out_ctrl_down),
    .out_alt_down   (out_alt_down),
    .out_altgr_down (out_altgr_down),
    .out_logo_down  (out_logo_down)
  );

  always #5 clk = ~clk;

  // Applies one scan byte to the predicted state; returns 1 when a key event results.
  function automatic bit decode_scan_byte(input logic [7:0] b, output key_evt_t evt);
    logic ext;
    evt = '0;
    if (b == PREFIX_BYTE) begin
      prefix_seen = 1'b1;
      return 1'b0;
    end
    ext = prefix_seen;
    prefix_seen = 1'b0;
    if (!ext) begin
      if (b == LSHIFT_MAKE || b == RSHIFT_MAKE) begin
        shift_on = 1'b1;
        return 1'b0;
      end
      if (b == LSHIFT_BREAK || b == RSHIFT_BREAK) begin
        shift_on = 1'b0;
        return 1'b0;
      end
      if (b == CTRL_MAKE || b == CTRL_BREAK) begin
        ctrl_on = (b == CTRL_MAKE);
        return 1'b0;
      end
      if (b == ALT_MAKE || b == ALT_BREAK) begin
        alt_on = (b == ALT_MAKE);
        return 1'b0;
      end
    end else begin
      if (b == ALT_MAKE || b == ALT_BREAK) begin
        altgr_on = (b == ALT_MAKE);
        return 1'b0;
      end
      if (b == LLOGO_MAKE || b == RLOGO_MAKE) begin
        logo_on = 1'b1;
        return 1'b0;
      end
      if (b == LLOGO_BREAK || b == RLOGO_BREAK) begin
        logo_on = 1'b0;
        return 1'b0;
      end
    end
    // Plain and extended codes share one down bit per low seven bits.
    if (b[7]) begin
      key_is_down[b[6:0]] = 1'b0;
    end else if (key_is_down[b[6:0]]) begin
      return 1'b0;
    end else begin
      key_is_down[b[6:0]] = 1'b1;
    end
    evt.extended   = ext;
    evt.key_code   = b;
    evt.is_release = b[7];
    evt.shift_down = shift_on;
    evt.ctrl_down  = ctrl_on;
    evt.alt_down   = alt_on;
    evt.altgr_down = altgr_on;
    evt.logo_down  = logo_on;
    return 1'b1;
  endfunction

  function automatic stim_row_t open_row(input logic [7:0] scan);
    stim_row_t r;
    r.scan   = scan;
    r.pinned = 1'b0;
    r.emits  = 1'b0;
    r.evt    = '0;
    return r;
  endfunction

  function automatic stim_row_t quiet_row(input logic [7:0] scan);
    stim_row_t r;
    r = open_row(scan);
    r.pinned = 1'b1;
    return r;
  endfunction

  // Expected event with no modifier held, as right after reset.
  function automatic stim_row_t pinned_row(input logic [7:0] scan, input logic [7:0] code,
                                           input logic rel);
    stim_row_t r;
    r = quiet_row(scan);
    r.emits          = 1'b1;
    r.evt.key_code   = code;
    r.evt.is_release = rel;
    return r;
  endfunction

  task automatic send_byte(input stim_row_t r);
    int unsigned gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_scan_byte <= r.scan;
    offered_rows.push_back(r);
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_key(input logic [8:0] k);
    if (k[8]) send_byte(open_row(PREFIX_BYTE));
    send_byte(open_row(k[7:0]));
    typed_count++;
  endtask

  task automatic drain_events();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
  endtask

  // One piece of typing: a key press, a release, autorepeat, a modifier, or line noise.
  task automatic random_gesture();
    int unsigned pick;
    int unsigned idx;
    logic [8:0] k;
    pick = $urandom_range(0, 99);
    if (pick < 35 && held_keys.size() < 12) begin
      k = {($urandom_range(0, 3) == 0), 1'b0, 7'($urandom_range(0, 127))};
      send_key(k);
      held_keys.push_back(k);
    end else if (pick < 60 && held_keys.size() != 0) begin
      idx = $urandom_range(0, held_keys.size() - 1);
      k = held_keys[idx];
      held_keys.delete(idx);
      k[7] = 1'b1;
      send_key(k);
    end else if (pick < 70 && held_keys.size() != 0) begin
      k = held_keys[$urandom_range(0, held_keys.size() - 1)];
      repeat ($urandom_range(1, 4)) send_key(k);
    end else if (pick < 85) begin
      send_key(modifier_keys[$urandom_range(0, 13)]);
    end else begin
      send_byte(open_row(8'($urandom_range(0, 255))));
      typed_count++;
    end
  endtask

  always @(posedge clk) begin : scoreboard
    stim_row_t r;
    key_evt_t predicted;
    key_evt_t want;
    bit fires;
    if (rst_n) begin
      // The request is handled before the result so a same-edge pass-through still lines up.
      if (in_valid && in_ready) begin
        r = offered_rows.pop_front();
        fires = decode_scan_byte(r.scan, predicted);
        if (r.pinned) begin
          if (r.emits) pending_events.push_back(r.evt);
        end else if (fires) begin
          pending_events.push_back(predicted);
        end
      end
      if (out_valid && out_ready) begin
        if (pending_events.size() == 0) begin
          $error("unexpected event: key_code %h", out_key_code);
          mismatch_count++;
        end else begin
          want = pending_events.pop_front();
          events_checked++;
          if (out_is_release) releases_seen++;
          if (out_extended) extended_seen++;
          if (out_extended !== want.extended) begin
            $error("extended: expected %b, got %b", want.extended, out_extended);
            mismatch_count++;
          end
          if (out_key_code !== want.key_code) begin
            $error("key_code: expected %h, got %h", want.key_code, out_key_code);
            mismatch_count++;
          end
          if (out_is_release !== want.is_release) begin
            $error("is_release: expected %b, got %b", want.is_release, out_is_release);
            mismatch_count++;
          end
          if (out_shift_down !== want.shift_down) begin
            $error("shift_down: expected %b, got %b", want.shift_down, out_shift_down);
            mismatch_count++;
          end
          if (out_ctrl_down !== want.ctrl_down) begin
            $error("ctrl_down: expected %b, got %b", want.ctrl_down, out_ctrl_down);
            mismatch_count++;
          end
          if (out_alt_down !== want.alt_down) begin
            $error("alt_down: expected %b, got %b", want.alt_down, out_alt_down);
            mismatch_count++;
          end
          if (out_altgr_down !== want.altgr_down) begin
            $error("altgr_down: expected %b, got %b", want.altgr_down, out_altgr_down);
            mismatch_count++;
          end
          if (out_logo_down !== want.logo_down) begin
            $error("logo_down: expected %b, got %b", want.logo_down, out_logo_down);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_long) begin
        out_ready <= 1'b0;
        repeat (60) @(negedge clk);
        hold_long = 1'b0;
        out_ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    stim_row_t directed_rows[$];
    foreach (key_is_down[i]) key_is_down[i] = 1'b0;
    modifier_keys = '{
      {1'b0, LSHIFT_MAKE}, {1'b0, RSHIFT_MAKE}, {1'b0, LSHIFT_BREAK}, {1'b0, RSHIFT_BREAK},
      {1'b0, CTRL_MAKE}, {1'b0, CTRL_BREAK}, {1'b0, ALT_MAKE}, {1'b0, ALT_BREAK},
      {1'b1, ALT_MAKE}, {1'b1, ALT_BREAK}, {1'b1, LLOGO_MAKE}, {1'b1, RLOGO_MAKE},
      {1'b1, LLOGO_BREAK}, {1'b1, RLOGO_BREAK}
    };
    directed_rows = '{
      pinned_row(8'h00, 8'h00, 1'b0),   // zero byte is an ordinary make
      quiet_row(8'h00),                 // same make again is a repeat
      pinned_row(8'h80, 8'h80, 1'b1),
      pinned_row(8'hFF, 8'hFF, 1'b1),   // break of a key that is not down
      pinned_row(8'h7F, 8'h7F, 1'b0),
      quiet_row(PREFIX_BYTE),
      quiet_row(PREFIX_BYTE),           // a second prefix stays pending
      quiet_row(ALT_MAKE),              // AltGr down
      quiet_row(PREFIX_BYTE),
      quiet_row(LLOGO_MAKE),            // logo down
      quiet_row(PREFIX_BYTE),
      open_row(CTRL_MAKE),              // extended ctrl is not a modifier
      quiet_row(LSHIFT_MAKE),
      quiet_row(CTRL_MAKE),
      quiet_row(ALT_MAKE),
      open_row(RLOGO_MAKE),             // logo code without prefix is a plain key
      quiet_row(PREFIX_BYTE),
      open_row(8'h48),
      open_row(8'h48),                  // plain code shares the extended down bit
      open_row(RLOGO_BREAK),
      quiet_row(LSHIFT_BREAK),
      quiet_row(PREFIX_BYTE),
      quiet_row(ALT_BREAK),
      quiet_row(PREFIX_BYTE),
      quiet_row(LLOGO_BREAK)
    };

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) send_byte(directed_rows[i]);
    drain_events();

    idle_on = 1'b1;
    while (bytes_sent < 300) random_gesture();

    // Long receiver stall with back-to-back breaks, so the event queue fills up.
    idle_on = 1'b0;
    hold_long = 1'b1;
    for (int c = 1; c <= 30; c++) send_byte(open_row(8'h80 | 8'(c)));
    idle_on = 1'b1;

    while (bytes_sent < 500) random_gesture();
    drain_events();
    while (bytes_sent < 650) random_gesture();

    idle_on = 1'b0;
    while (bytes_sent < 750) random_gesture();

    drain_events();
    repeat (8) @(posedge clk);

    $display("Sent %0d scan bytes in %0d typed gestures, including a queue-full stall.",
             bytes_sent, typed_count);
    $display("Checked %0d key events (%0d breaks, %0d extended).",
             events_checked, releases_seen, extended_seen);
    if (mismatch_count == 0 && pending_events.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ ps2_set1_scancode_decoder.f @@
+incdir+hw/rtl
hw/rtl/ps2s1_pkg.sv
hw/rtl/ps2s1_front.sv
hw/rtl/ps2s1_fifo.sv
hw/rtl/ps2_set1_scancode_decoder.sv
test/testbench.sv
